// ----- rtl/sccrc_pkg.sv -----
// Package for the selectable CRC engine: CRC type codes, polynomials and
// initial values. No dependencies.
package sccrc_pkg;

  // CRC type codes as written to the configuration register.
  typedef enum logic [1:0] {
    CRC_NONE = 2'd0,
    CRC_8    = 2'd1,
    CRC_16   = 2'd2,
    CRC_32   = 2'd3
  } crc_type_t;

  localparam int unsigned RemW = 32;

  typedef logic [RemW-1:0] rem_t;

  localparam logic [7:0]  Poly8  = 8'h1D;
  localparam logic [15:0] Poly16 = 16'h1021;
  localparam logic [31:0] Poly32 = 32'h04C1_1DB7;
  localparam logic [7:0]  Init8  = 8'hFF;
  localparam logic [15:0] Init16 = 16'hFFFF;
  localparam logic [31:0] Init32 = 32'hFFFF_FFFF;

  localparam crc_type_t CrcTypeReset = CRC_32;

  // Initial remainder of a CRC type, zero-extended to the remainder width.
  function automatic rem_t init_for(input crc_type_t t);
    rem_t v;
    v = '0;
    unique case (t)
      CRC_8:   v = {24'd0, Init8};
      CRC_16:  v = {16'd0, Init16};
      CRC_32:  v = Init32;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/sccrc_if.sv -----
// Handshake channels of the selectable CRC engine: input bytes, results and
// the configuration write. No dependencies.

// Input channel: one byte of a data block, or an empty block end.
interface sccrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       carries_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output carries_byte,
                  output last_byte, input ready);
  modport sink (input valid, input data_byte, input carries_byte,
                input last_byte, output ready);
endinterface

// Result channel: the finished CRC of one block.
interface sccrc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] crc_value;

  modport source (output valid, output crc_value, input ready);
  modport sink (input valid, input crc_value, output ready);
endinterface

// Configuration channel: write data of the CRC type register.
interface sccrc_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] crc_type;

  modport source (output valid, output crc_type, input ready);
  modport sink (input valid, input crc_type, output ready);
endinterface

// ----- rtl/sccrc_fold.sv -----
// Byte-wide CRC update for the selectable CRC engine: folds one byte into
// the running remainder, MSB first, eight bit steps unrolled.
// Depends on sccrc_pkg.
module sccrc_fold (
  input  sccrc_pkg::crc_type_t crc_type,
  input  sccrc_pkg::rem_t      rem,
  input  logic [7:0]           data_byte,
  output sccrc_pkg::rem_t      rem_next
);

  sccrc_pkg::rem_t rem_al;
  sccrc_pkg::rem_t poly_al;
  sccrc_pkg::rem_t work;

  // Align the remainder and polynomial to the top of a 32-bit word, so one
  // shift chain serves all three widths; the low bits only ever shift in zeros.
  always_comb begin
    unique case (crc_type)
      sccrc_pkg::CRC_8: begin
        rem_al  = {rem[7:0], 24'd0};
        poly_al = {sccrc_pkg::Poly8, 24'd0};
      end
      sccrc_pkg::CRC_16: begin
        rem_al  = {rem[15:0], 16'd0};
        poly_al = {sccrc_pkg::Poly16, 16'd0};
      end
      sccrc_pkg::CRC_32: begin
        rem_al  = rem;
        poly_al = sccrc_pkg::Poly32;
      end
      default: begin
        rem_al  = '0;
        poly_al = '0;
      end
    endcase
  end

  // Eight conditional shift-and-subtract steps, one per data bit.
  always_comb begin
    work = rem_al ^ {data_byte, 24'd0};
    for (int b = 0; b < 8; b++) begin
      if (work[31]) begin
        work = {work[30:0], 1'b0} ^ poly_al;
      end else begin
        work = {work[30:0], 1'b0};
      end
    end
  end

  // Return the result to its natural width, zero-extended.
  always_comb begin
    unique case (crc_type)
      sccrc_pkg::CRC_8:  rem_next = {24'd0, work[31:24]};
      sccrc_pkg::CRC_16: rem_next = {16'd0, work[31:16]};
      sccrc_pkg::CRC_32: rem_next = work;
      default:           rem_next = '0;
    endcase
  end

endmodule

// ----- rtl/selectable_crc8_16_32_engine_unit.sv -----
// Top level of the selectable CRC engine (CRC-8, CRC-16, CRC-32, MSB first).
// Depends on sccrc_pkg, the channel interfaces in sccrc_if and sccrc_fold.
//
// Usage:
//   feed   : input channel, one item per transfer. An item carrying a byte
//            folds it into the running remainder; an item with last_byte set,
//            or any item without a byte, ends the block and yields one result.
//   result : output channel carrying the finished CRC, zero-extended to 32
//            bits. Type none always returns zero.
//   cfg    : write channel for the CRC type register (0 none, 1 CRC-8,
//            2 CRC-16, 3 CRC-32). A write reloads the remainder with the new
//            type's initial value; write it only while the engine is idle.
// Timing: an accepted item is held in an input register, then the unrolled
//   byte update runs into the remainder and result registers. The result is
//   registered: it is valid once the item that ends the block has left the
//   input register. One item is taken every cycle, unless a waiting result
//   holds back an item that ends a block.
// Reset: the type returns to CRC-32 and the remainder to 0xFFFFFFFF.
// Stall: a waiting result holds in its register; the input register still
//   takes items that produce no result, and further items wait behind one
//   that ends a block until the result register frees.
module selectable_crc8_16_32_engine_unit (
  input logic                clk,
  input logic                rst,
  sccrc_cfg_if.sink          cfg,
  sccrc_in_if.sink           feed,
  sccrc_out_if.source        result
);

  // Input register.
  logic       in_q_valid;
  logic [7:0] in_q_byte;
  logic       in_q_carries;
  logic       in_q_last;

  // Processing state.
  sccrc_pkg::crc_type_t crc_type;
  sccrc_pkg::rem_t      remainder;
  sccrc_pkg::rem_t      remainder_next;
  sccrc_pkg::rem_t      folded;

  // Result register.
  logic        res_valid;
  logic [31:0] res_value;

  logic ends_block;
  logic out_free;
  logic advance;
  logic cfg_write;

  assign cfg.ready = 1'b1;
  assign cfg_write = cfg.valid && cfg.ready;

  // An item leaves the input register once its result, if any, has room.
  assign ends_block = !in_q_carries || in_q_last;
  assign out_free   = !res_valid || result.ready;
  assign advance    = in_q_valid && (!ends_block || out_free);
  assign feed.ready = !in_q_valid || advance;

  assign result.valid     = res_valid;
  assign result.crc_value = res_value;

  // Input register capture.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (feed.ready) begin
      in_q_valid <= feed.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (feed.valid && feed.ready) begin
      in_q_byte    <= feed.data_byte;
      in_q_carries <= feed.carries_byte;
      in_q_last    <= feed.last_byte;
    end
  end

  sccrc_fold u_fold (
    .crc_type  (crc_type),
    .rem       (remainder),
    .data_byte (in_q_byte),
    .rem_next  (folded)
  );

  // Remainder after this item, before any reload at the block end.
  assign remainder_next = in_q_carries ? folded : remainder;

  // CRC type register and running remainder.
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_type  <= sccrc_pkg::CrcTypeReset;
      remainder <= sccrc_pkg::init_for(sccrc_pkg::CrcTypeReset);
    end else if (cfg_write) begin
      crc_type  <= sccrc_pkg::crc_type_t'(cfg.crc_type);
      remainder <= sccrc_pkg::init_for(sccrc_pkg::crc_type_t'(cfg.crc_type));
    end else if (advance) begin
      if (ends_block) begin
        remainder <= sccrc_pkg::init_for(crc_type);
      end else begin
        remainder <= remainder_next;
      end
    end
  end

  // Result register: loaded when a block ends, cleared when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && ends_block) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && ends_block) begin
      res_value <= (crc_type == sccrc_pkg::CRC_NONE) ? '0 : remainder_next;
    end
  end

  // The remainder never holds bits above the selected CRC width.
  a_rem_width: assert property (@(posedge clk) disable iff (rst)
    ((crc_type != sccrc_pkg::CRC_8) || (remainder[31:8] == 24'd0)) &&
    ((crc_type != sccrc_pkg::CRC_16) || (remainder[31:16] == 16'd0)) &&
    ((crc_type != sccrc_pkg::CRC_NONE) || (remainder == '0)))
    else $error("remainder has bits beyond the selected CRC width");

  // A register write leaves the remainder at the new type's initial value.
  a_cfg_reload: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> (remainder == sccrc_pkg::init_for(crc_type)))
    else $error("remainder not reloaded after a type write");

  // An item held in the input register is not dropped while it waits.
  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    (in_q_valid && !advance) |=> in_q_valid)
    else $error("waiting input item lost");

endmodule
